### sv/sd_spi_command_engine_macros.svh
// ----------------------------------------------------------------------------
// SD SPI command engine assertion macros
// Shared concurrent assertion forms; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_COMMAND_ENGINE_MACROS_SVH
`define SD_SPI_COMMAND_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SDSCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SDSCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SDSCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SDSCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/sdsce_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI command engine package
// Transaction types, protocol constants and the command frame builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdsce_pkg;

  localparam logic       OP_START = 1'b0;

  localparam logic [2:0] RT_R1      = 3'd0;
  localparam logic [2:0] RT_R1B     = 3'd1;
  localparam logic [2:0] RT_R2      = 3'd2;
  localparam logic [2:0] RT_R5      = 3'd3;
  localparam logic [2:0] RT_R3      = 3'd4;
  localparam logic [2:0] RT_R4      = 3'd5;
  localparam logic [2:0] RT_R7      = 3'd6;
  localparam logic [2:0] RT_R1_DATA = 3'd7;

  localparam logic [7:0] CMD_TX_BIT = 8'h40;
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] CRC_NONE   = 8'h00;
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] BYTE_BUSY  = 8'h00;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;

  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;

  localparam logic [7:0] ATTEMPTS_RESET = 8'd10;
  localparam int         STATUS_BYTES   = 16;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [2:0]  resp_type;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
  } result_t;

  // Byte k of the six-byte command frame.
  function automatic logic [7:0] frame_byte(logic [5:0] idx, logic [31:0] arg,
                                            logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0: b = {2'b00, idx} | CMD_TX_BIT;
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: begin
        if (idx == CMD_GO_IDLE) begin
          b = CRC_CMD0;
        end else if (idx == CMD_SEND_IF_COND) begin
          b = CRC_CMD8;
        end else begin
          b = CRC_NONE;
        end
      end
    endcase
    return b;
  endfunction

endpackage

### sv/sdsce_in_if.sv
// ----------------------------------------------------------------------------
// SD SPI command engine input channel
// Valid/ready channel carrying one command start or one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sdsce_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic [2:0]  resp_type;
  logic [7:0]  rx_byte;

  modport source (output valid, output opcode, output cmd_index, output cmd_arg,
                  output resp_type, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input cmd_index, input cmd_arg,
                  input resp_type, input rx_byte, output ready);
endinterface

### sv/sdsce_out_if.sv
// ----------------------------------------------------------------------------
// SD SPI command engine result channel
// Valid/ready channel carrying the next link byte and the response words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sdsce_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        done_res;
  logic [31:0] resp_word0;
  logic [31:0] resp_word1;
  logic [31:0] resp_word2;
  logic [31:0] resp_word3;

  modport source (output valid, output tx_valid, output tx_byte, output done_res,
                  output resp_word0, output resp_word1, output resp_word2,
                  output resp_word3, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input done_res,
                  input resp_word0, input resp_word1, input resp_word2,
                  input resp_word3, output ready);
endinterface

### sv/sd_spi_command_engine.sv
// ----------------------------------------------------------------------------
// SD SPI command engine
// SPI-mode SD command sequencer: frames a command and collects its response.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Carries
//   in_ch     in         valid/ready     command start or one received byte
//   out_ch    out        valid/ready     next link byte, done, response words
//   cfg_*     in         write enable    response attempt count
//
// One transaction is accepted per cycle while out_ch is not stalled. The
// sequencer step runs between the input register and the result register;
// a result is loaded into the result register as its input leaves the input
// register. Reset is synchronous and active low; valid flags and sequencer
// state clear with no clearing pass, and the attempt count returns to ten.
// When out_ch is stalled the result register holds. An empty input register
// still takes one more transaction; once it is full, in_ch.ready follows
// out_ch.ready in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sd_spi_command_engine (
  input  logic             clk,
  input  logic             rst_n,
  sdsce_in_if.sink         in_ch,
  sdsce_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);
  import sdsce_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  result_t step_res;
  result_t out_res;
  logic    stage_fire;
  logic    out_can_load;

  // Gather the input transaction fields into one word.
  assign in_item.opcode    = in_ch.opcode;
  assign in_item.cmd_index = in_ch.cmd_index;
  assign in_item.cmd_arg   = in_ch.cmd_arg;
  assign in_item.resp_type = in_ch.resp_type;
  assign in_item.rx_byte   = in_ch.rx_byte;

  // Input register: it advances whenever the result register can take the
  // sequencer's answer, so the two sides never wait on each other needlessly.
  sdsce_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .down_ready (out_can_load),
    .fire       (stage_fire),
    .item       (stage_item)
  );

  // Sequencer: the command state is updated exactly when a transaction moves
  // from the input register to the result register.
  sdsce_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (stage_fire),
    .item      (stage_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (step_res)
  );

  // Result register.
  sdsce_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stage_fire),
    .load_res  (step_res),
    .can_load  (out_can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.tx_valid   = out_res.tx_valid;
  assign out_ch.tx_byte    = out_res.tx_byte;
  assign out_ch.done_res   = out_res.done_res;
  assign out_ch.resp_word0 = out_res.resp_word0;
  assign out_ch.resp_word1 = out_res.resp_word1;
  assign out_ch.resp_word2 = out_res.resp_word2;
  assign out_ch.resp_word3 = out_res.resp_word3;

endmodule

### sv/sdsce_in_stage.sv
// ----------------------------------------------------------------------------
// SD SPI command engine input register
// Holds one accepted transaction until the sequencer consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsce_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdsce_pkg::item_t in_item,
  input  logic            down_ready,
  output logic            fire,
  output sdsce_pkg::item_t item
);
  import sdsce_pkg::*;

  logic  valid_r;
  item_t item_r;

  // The register frees up in the same cycle that its content moves on.
  assign fire     = valid_r && down_ready;
  assign in_ready = !valid_r || down_ready;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### sv/sdsce_step.sv
// ----------------------------------------------------------------------------
// SD SPI command engine sequencer
// Command state, status bytes and the per-transaction next-byte logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sd_spi_command_engine_macros.svh"

module sdsce_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sdsce_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output sdsce_pkg::result_t res
);
  import sdsce_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_READY, PH_SEND, PH_R1, PH_BUSY, PH_SKIP, PH_TAKE4, PH_WAITFE, PH_TAKE16
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [7:0]  attempts_r, attempts_nxt;
  logic [7:0]  resp_attempts_r;
  logic [5:0]  index_r, index_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [2:0]  type_r, type_nxt;
  logic [7:0]  status_r   [STATUS_BYTES];
  logic [7:0]  status_nxt [STATUS_BYTES];

  logic        do_after, do_finish, do_read;
  logic [7:0]  attempts_dec;
  logic [4:0]  count_inc, count_dec;

  assign attempts_dec = attempts_r - 8'd1;
  assign count_inc    = count_r + 5'd1;
  assign count_dec    = count_r - 5'd1;

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    attempts_nxt = attempts_r;
    index_nxt    = index_r;
    arg_nxt      = arg_r;
    type_nxt     = type_r;
    status_nxt   = status_r;
    res          = '0;
    do_after     = 1'b0;
    do_finish    = 1'b0;
    do_read      = 1'b0;

    if (item.opcode == OP_START) begin
      // A start always aborts whatever command is running.
      index_nxt    = item.cmd_index;
      arg_nxt      = item.cmd_arg;
      type_nxt     = item.resp_type;
      for (int i = 0; i < STATUS_BYTES; i++) begin
        status_nxt[i] = '0;
      end
      phase_nxt    = PH_READY;
      count_nxt    = '0;
      attempts_nxt = '0;
      do_read      = 1'b1;
    end else begin
      unique case (phase_r)
        PH_READY: begin
          if (item.rx_byte != BYTE_IDLE) begin
            do_read = 1'b1;
          end else begin
            phase_nxt    = PH_SEND;
            count_nxt    = 5'd1;
            res.tx_valid = 1'b1;
            res.tx_byte  = frame_byte(index_r, arg_r, 3'd0);
          end
        end
        PH_SEND: begin
          if (count_r < 5'd6) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = frame_byte(index_r, arg_r, count_r[2:0]);
            count_nxt    = count_inc;
          end else begin
            phase_nxt    = PH_R1;
            count_nxt    = '0;
            attempts_nxt = resp_attempts_r;
            do_read      = 1'b1;
          end
        end
        PH_R1: begin
          status_nxt[15] = item.rx_byte;
          if (item.rx_byte == BYTE_IDLE) begin
            // A zero setting wraps to 256 reads.
            attempts_nxt = attempts_dec;
            if (attempts_dec != 8'd0) begin
              do_read = 1'b1;
            end else begin
              do_after = 1'b1;
            end
          end else begin
            do_after = 1'b1;
          end
        end
        PH_BUSY: begin
          if (item.rx_byte == BYTE_BUSY) begin
            do_read = 1'b1;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_SKIP: begin
          count_nxt = count_dec;
          if (count_dec == 5'd0) begin
            do_finish = 1'b1;
          end else begin
            do_read = 1'b1;
          end
        end
        PH_TAKE4: begin
          status_nxt[{2'b11, count_r[1:0]}] = item.rx_byte;
          count_nxt = count_inc;
          if (count_inc >= 5'd4) begin
            do_finish = 1'b1;
          end else begin
            do_read = 1'b1;
          end
        end
        PH_WAITFE: begin
          if (item.rx_byte == TOKEN_DATA) begin
            phase_nxt = PH_TAKE16;
            count_nxt = '0;
          end
          do_read = 1'b1;
        end
        PH_TAKE16: begin
          status_nxt[count_r[3:0]] = item.rx_byte;
          count_nxt = count_inc;
          if (count_inc >= 5'd16) begin
            // Two CRC bytes follow the data block.
            phase_nxt = PH_SKIP;
            count_nxt = 5'd2;
          end
          do_read = 1'b1;
        end
        default: begin
          // A received byte with no command running yields an empty result.
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (do_after) begin
      unique case (type_r)
        RT_R1B: begin
          phase_nxt = PH_BUSY;
          do_read   = 1'b1;
        end
        RT_R2, RT_R5: begin
          phase_nxt = PH_SKIP;
          count_nxt = 5'd1;
          do_read   = 1'b1;
        end
        RT_R3, RT_R4, RT_R7: begin
          phase_nxt = PH_TAKE4;
          count_nxt = '0;
          do_read   = 1'b1;
        end
        RT_R1_DATA: begin
          phase_nxt = PH_WAITFE;
          do_read   = 1'b1;
        end
        RT_R1: begin
          do_finish = 1'b1;
        end
      endcase
    end

    if (do_read) begin
      res.tx_valid = 1'b1;
      res.tx_byte  = BYTE_IDLE;
    end

    if (do_finish) begin
      phase_nxt      = PH_IDLE;
      count_nxt      = '0;
      res.tx_valid   = 1'b0;
      res.tx_byte    = '0;
      res.done_res   = 1'b1;
      res.resp_word0 = {status_nxt[12], status_nxt[13], status_nxt[14], status_nxt[15]};
      res.resp_word1 = {status_nxt[8], status_nxt[9], status_nxt[10], status_nxt[11]};
      res.resp_word2 = {status_nxt[4], status_nxt[5], status_nxt[6], status_nxt[7]};
      res.resp_word3 = {status_nxt[0], status_nxt[1], status_nxt[2], status_nxt[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      count_r         <= '0;
      attempts_r      <= '0;
      index_r         <= '0;
      arg_r           <= '0;
      type_r          <= '0;
      resp_attempts_r <= ATTEMPTS_RESET;
      for (int i = 0; i < STATUS_BYTES; i++) begin
        status_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        resp_attempts_r <= cfg_wdata;
      end
      if (fire) begin
        phase_r    <= phase_nxt;
        count_r    <= count_nxt;
        attempts_r <= attempts_nxt;
        index_r    <= index_nxt;
        arg_r      <= arg_nxt;
        type_r     <= type_nxt;
        status_r   <= status_nxt;
      end
    end
  end

  `SDSCE_ASSERT_IMP(a_done_no_tx, clk, rst_n, fire && res.done_res, !res.tx_valid, "done with tx")
  `SDSCE_ASSERT_IMP(a_tx_zero, clk, rst_n, fire && !res.tx_valid, res.tx_byte == 8'd0, "stray tx byte")
  `SDSCE_ASSERT_IMP(a_send_count, clk, rst_n, phase_r == PH_SEND, count_r >= 5'd1 && count_r <= 5'd6, "frame count out of range")
  `SDSCE_ASSERT_NXT(a_start_ready, clk, rst_n, fire && item.opcode == OP_START, phase_r == PH_READY, "start did not poll ready")
  `SDSCE_ASSERT_NXT(a_done_idle, clk, rst_n, fire && res.done_res, phase_r == PH_IDLE && count_r == 5'd0, "done left engine busy")

endmodule

### sv/sdsce_out_stage.sv
// ----------------------------------------------------------------------------
// SD SPI command engine result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsce_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sdsce_pkg::result_t  load_res,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output sdsce_pkg::result_t  out_res
);
  import sdsce_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
    if (can_load && load) begin
      res_r <= load_res;
    end
  end

endmodule
